// File: hw/rtl/dgre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgre_pkg: shared types, codes and helpers
// Fixed-point formats, status and opcode constants and the rounding helpers
// used by the matrix build and the fold stages.
// ----------------------------------------------------------------------------
package dgre_pkg;

  localparam int QQ_SHIFT   = 14;
  localparam int RND_SHIFT  = 16;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 34;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic CFG_VISC = 1'b0;
  localparam logic CFG_DIFF = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_COMPLEX    = 2'd1;
  localparam logic [1:0] ST_TRACE_ZERO = 2'd2;
  localparam logic [1:0] ST_ZERO_ROOT  = 2'd3;

  typedef logic signed [31:0] fix_t;

  typedef struct packed {
    logic signed [32:0] trace;
    logic signed [63:0] cdet;
    logic               tz;
    logic               neg;
  } sqrt_side_t;

  typedef struct packed {
    logic signed [33:0] lam1;
    logic signed [33:0] fixed_val;
    logic [1:0]         status;
    logic               qneg;
  } div_side_t;

  function automatic fix_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Sum of four rescaled products, rounded half up to the working format.
  function automatic logic signed [34:0] qround(input logic signed [48:0] a,
                                                input logic signed [48:0] b,
                                                input logic signed [48:0] c,
                                                input logic signed [48:0] d);
    logic signed [50:0] acc;
    acc = 51'(a) + 51'(b) + 51'(c) + 51'(d) + (51'sd1 <<< (RND_SHIFT - 1));
    return 35'(acc >>> RND_SHIFT);
  endfunction

endpackage

// File: hw/rtl/dgre_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgre_cfg_if: configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface dgre_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/dgre_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgre_in_if: input item channel
// Carries a coefficient load or a direction to evaluate.
// ----------------------------------------------------------------------------
interface dgre_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [5:0]         coef_index;
  logic signed [31:0] coef_value;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  modport source(output valid, output operation, output coef_index, output coef_value,
                 output dir_x, output dir_y, input ready);
  modport sink(input valid, input operation, input coef_index, input coef_value,
               input dir_x, input dir_y, output ready);
endinterface

// File: hw/rtl/dgre_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgre_out_if: result channel
// Carries both eigenvalues and the status code.
// ----------------------------------------------------------------------------
interface dgre_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] lambda_large;
  logic signed [31:0] lambda_small;
  logic [1:0]         status;
  modport source(output valid, output lambda_large, output lambda_small, output status,
                 input ready);
  modport sink(input valid, input lambda_large, input lambda_small, input status,
               output ready);
endinterface

// File: hw/rtl/dgre_mat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgre_mat: coefficient table and 4x4 matrix build
// Four stages: input register, direction products, 64 coefficient products,
// then the negated, saturated rounded sums with viscosity/diffusivity on the diagonal.
// ----------------------------------------------------------------------------
module dgre_mat import dgre_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               in_valid_i,
  input  logic               in_op_i,
  input  logic [5:0]         in_idx_i,
  input  fix_t               in_val_i,
  input  logic signed [15:0] in_x_i,
  input  logic signed [15:0] in_y_i,
  input  logic [30:0]        visc_i,
  input  logic [30:0]        diff_i,
  output logic               valid_o,
  output fix_t               e_o [4][4],
  output fix_t               w_o [4]
);

  logic               s1_valid_q;
  logic               s1_op_q;
  logic [5:0]         s1_idx_q;
  fix_t               s1_val_q;
  logic signed [15:0] s1_x_q, s1_y_q;
  fix_t               tab_q [64];

  logic               s2_valid_q;
  fix_t               s2_xx_q, s2_xy_q, s2_yy_q;

  logic               s3_valid_q;
  logic signed [48:0] s3_prod_q [64];
  logic signed [48:0] prod_d [64];
  fix_t               s3_xx_q, s3_xy_q, s3_yy_q;

  logic               s4_valid_q;
  fix_t               e_q [4][4];
  fix_t               e_d [4][4];
  fix_t               s4_w_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q && (s1_op_q == OP_EVAL);
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_op_q   <= in_op_i;
      s1_idx_q  <= in_idx_i;
      s1_val_q  <= in_val_i;
      s1_x_q    <= in_x_i;
      s1_y_q    <= in_y_i;
      s2_xx_q   <= s1_x_q * s1_x_q;
      s2_xy_q   <= s1_x_q * s1_y_q;
      s2_yy_q   <= s1_y_q * s1_y_q;
      s3_prod_q <= prod_d;
      s3_xx_q   <= s2_xx_q;
      s3_xy_q   <= s2_xy_q;
      s3_yy_q   <= s2_yy_q;
      e_q       <= e_d;
      s4_w_q[0] <= s3_yy_q;
      s4_w_q[1] <= -s3_xy_q;
      s4_w_q[2] <= -s3_xy_q;
      s4_w_q[3] <= s3_xx_q;
    end
  end

  // A load writes as it leaves the first stage, so an evaluation ahead of it
  // has already taken its products and one behind it sees the new value.
  always_ff @(posedge clk_i) begin
    if (en_i && s1_valid_q && (s1_op_q == OP_LOAD)) begin
      tab_q[s1_idx_q] <= s1_val_q;
    end
  end

  for (genvar n = 0; n < 64; n++) begin : g_prod
    localparam int JK = (n >> 1) & 3;
    fix_t               w;
    logic signed [63:0] p;
    assign w = (JK == 0) ? s2_xx_q : ((JK == 3) ? s2_yy_q : s2_xy_q);
    assign p = tab_q[n] * w;
    assign prod_d[n] = 49'(p >>> QQ_SHIFT);
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar i = 0; i < 4; i++) begin : g_col
      localparam int BASE = ((r >> 1) << 5) | (i << 3) | (r & 1);
      logic signed [34:0] qs;
      logic signed [35:0] s;
      logic signed [36:0] ng;
      assign qs = qround(s3_prod_q[BASE], s3_prod_q[BASE + 2],
                         s3_prod_q[BASE + 4], s3_prod_q[BASE + 6]);
      if (r == i) begin : g_diag
        assign s = 36'(qs) + $signed({5'b0, (r < 2) ? visc_i : diff_i});
      end else begin : g_off
        assign s = 36'(qs);
      end
      assign ng = -37'(s);
      assign e_d[r][i] = sat32(64'(ng));
    end
  end

  assign valid_o = s4_valid_q;
  assign e_o     = e_q;
  assign w_o     = s4_w_q;

endmodule

// File: hw/rtl/dgre_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgre_fold: fold to 2x2 and form trace, determinant and discriminant
// Five stages: fold products, rounded 2x2 entries, trace and difference,
// the three wide products, then determinant and quarter-discriminant.
// ----------------------------------------------------------------------------
module dgre_fold import dgre_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  fix_t               e_i [4][4],
  input  fix_t               w_i [4],
  output logic               valid_o,
  output logic [63:0]        rad_o,
  output sqrt_side_t         side_o
);

  logic               s5_valid_q, s6_valid_q, s7_valid_q, s8_valid_q, s9_valid_q;
  logic signed [48:0] f_d [16];
  logic signed [48:0] f_q [16];
  fix_t               m_d [4];
  fix_t               m_q [4];

  logic signed [32:0] t7_d, d7;
  logic [31:0]        ud7_d;
  logic signed [32:0] t7_q;
  logic [31:0]        ud7_q;
  fix_t               m00_7_q, m01_7_q, m10_7_q, m11_7_q;

  logic [63:0]        usq_q;
  logic signed [63:0] p_q, pm_q;
  logic signed [32:0] t8_q;

  logic signed [63:0] rad_d;
  logic signed [63:0] rad_q;
  sqrt_side_t         side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
      s7_valid_q <= 1'b0;
      s8_valid_q <= 1'b0;
      s9_valid_q <= 1'b0;
    end else if (en_i) begin
      s5_valid_q <= valid_i;
      s6_valid_q <= s5_valid_q;
      s7_valid_q <= s6_valid_q;
      s8_valid_q <= s7_valid_q;
      s9_valid_q <= s8_valid_q;
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_a
    for (genvar b = 0; b < 2; b++) begin : g_b
      for (genvar n = 0; n < 4; n++) begin : g_n
        logic signed [63:0] p;
        assign p = e_i[2 * a + (n >> 1)][2 * b + (n & 1)] * w_i[n];
        assign f_d[a * 8 + b * 4 + n] = 49'(p >>> QQ_SHIFT);
      end
      assign m_d[a * 2 + b] = sat32(64'(qround(f_q[a * 8 + b * 4], f_q[a * 8 + b * 4 + 1],
                                               f_q[a * 8 + b * 4 + 2],
                                               f_q[a * 8 + b * 4 + 3])));
    end
  end

  assign t7_d  = 33'(m_q[0]) + 33'(m_q[3]);
  assign d7    = 33'(m_q[0]) - 33'(m_q[3]);
  assign ud7_d = d7[32] ? 32'(-d7) : d7[31:0];

  assign rad_d = $signed({2'b00, usq_q[63:2]}) + p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q          <= f_d;
      m_q          <= m_d;
      t7_q         <= t7_d;
      ud7_q        <= ud7_d;
      m00_7_q      <= m_q[0];
      m01_7_q      <= m_q[1];
      m10_7_q      <= m_q[2];
      m11_7_q      <= m_q[3];
      usq_q        <= ud7_q * ud7_q;
      p_q          <= m01_7_q * m10_7_q;
      pm_q         <= m00_7_q * m11_7_q;
      t8_q         <= t7_q;
      rad_q        <= rad_d;
      side_q.trace <= t8_q;
      side_q.cdet  <= pm_q - p_q;
      side_q.tz    <= (t8_q == 33'sd0);
      side_q.neg   <= rad_d[63];
    end
  end

  assign valid_o = s9_valid_q;
  assign rad_o   = rad_q;
  assign side_o  = side_q;

endmodule

// File: hw/rtl/dgre_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgre_sqrt: pipelined integer square root
// One result bit per stage, remainder carried from stage to stage.
// ----------------------------------------------------------------------------
module dgre_sqrt import dgre_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [63:0] rad_i,
  input  sqrt_side_t  side_i,
  output logic        valid_o,
  output logic [31:0] root_o,
  output sqrt_side_t  side_o
);

  logic        v_q    [SQRT_STEPS];
  logic [65:0] rem_q  [SQRT_STEPS];
  logic [31:0] root_q [SQRT_STEPS];
  sqrt_side_t  side_q [SQRT_STEPS];

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
    localparam int B = SQRT_STEPS - 1 - s;
    logic        v_in;
    logic [65:0] rem_in, test, rem_nx;
    logic [31:0] root_in, root_nx;
    sqrt_side_t  side_in;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = {2'b00, rad_i};
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[s - 1];
      assign rem_in  = rem_q[s - 1];
      assign root_in = root_q[s - 1];
      assign side_in = side_q[s - 1];
    end

    // (R + 2^B)^2 - R^2 with R holding only the bits above B.
    assign test = (66'(root_in) << (B + 1)) + (66'd1 << (2 * B));

    always_comb begin
      if (rem_in >= test) begin
        rem_nx  = rem_in - test;
        root_nx = root_in | (32'd1 << B);
      end else begin
        rem_nx  = rem_in;
        root_nx = root_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_nx;
        root_q[s] <= root_nx;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = v_q[SQRT_STEPS - 1];
  assign root_o  = root_q[SQRT_STEPS - 1];
  assign side_o  = side_q[SQRT_STEPS - 1];

endmodule

// File: hw/rtl/dgre_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgre_div: pipelined restoring divider for the second root
// One quotient bit per stage; quotients of 2^34 and above are flagged.
// ----------------------------------------------------------------------------
module dgre_div import dgre_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [63:0] num_i,
  input  logic [33:0] den_i,
  input  div_side_t   side_i,
  output logic        valid_o,
  output logic [33:0] quot_o,
  output logic        ovf_o,
  output div_side_t   side_o
);

  logic        v_q    [DIV_STEPS];
  logic [33:0] rem_q  [DIV_STEPS];
  logic [33:0] quot_q [DIV_STEPS];
  logic [33:0] low_q  [DIV_STEPS];
  logic [33:0] den_q  [DIV_STEPS];
  logic        ovf_q  [DIV_STEPS];
  div_side_t   side_q [DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    localparam int B = DIV_STEPS - 1 - s;
    logic        v_in, ovf_in;
    logic [33:0] rem_in, quot_in, low_in, den_in, rem_nx, quot_nx;
    logic [34:0] sh;
    div_side_t   side_in;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = {4'b0, num_i[63:34]};
      assign quot_in = '0;
      assign low_in  = num_i[33:0];
      assign den_in  = den_i;
      assign ovf_in  = ({4'b0, num_i[63:34]} >= den_i);
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[s - 1];
      assign rem_in  = rem_q[s - 1];
      assign quot_in = quot_q[s - 1];
      assign low_in  = low_q[s - 1];
      assign den_in  = den_q[s - 1];
      assign ovf_in  = ovf_q[s - 1];
      assign side_in = side_q[s - 1];
    end

    assign sh = {rem_in, low_in[B]};

    always_comb begin
      if (sh >= {1'b0, den_in}) begin
        rem_nx  = 34'(sh - {1'b0, den_in});
        quot_nx = quot_in | (34'd1 << B);
      end else begin
        rem_nx  = sh[33:0];
        quot_nx = quot_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_nx;
        quot_q[s] <= quot_nx;
        low_q[s]  <= low_in;
        den_q[s]  <= den_in;
        ovf_q[s]  <= ovf_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = v_q[DIV_STEPS - 1];
  assign quot_o  = quot_q[DIV_STEPS - 1];
  assign ovf_o   = ovf_q[DIV_STEPS - 1];
  assign side_o  = side_q[DIV_STEPS - 1];

endmodule

// File: hw/rtl/directional_growth_rate_eigen_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// directional_growth_rate_eigen_top: directional growth-rate eigenvalues
// Coefficient table, 4x4 matrix build, fold to 2x2 and both eigenvalues.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_i  writes viscosity (index 0) or diffusivity (index 1); always ready.
//          Write only while no evaluation is in flight.
//   in_i   takes one beat per cycle while ready. operation 0 stores
//          coef_value at coef_index and returns nothing; operation 1
//          evaluates the direction (dir_x, dir_y) and returns one beat on out_o.
//   out_o  lambda_large, lambda_small and status for each evaluation, in
//          order.
// The beat passes 77 register stages, the first loaded at the accepting
// edge: four of matrix build, five of fold and determinant, 32 of the
// square-root pipeline, one for the first root, 34 of the divider and
// the output register. The block takes one beat per cycle while
// in_i.ready is high.
// Reset clears the configuration registers and the valid bits, emptying the
// pipeline; the table keeps no reset and must be loaded before use.
// When out_o stalls, a skid register catches one more result and in_i.ready
// then drops until the sink takes a beat; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module directional_growth_rate_eigen_top import dgre_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  dgre_cfg_if.sink  cfg_i,
  dgre_in_if.sink   in_i,
  dgre_out_if.source out_o
);

  logic        en;
  logic [30:0] visc_q, diff_q;

  logic        mat_valid;
  fix_t        mat_e [4][4];
  fix_t        mat_w [4];

  logic        fold_valid;
  logic [63:0] fold_rad;
  sqrt_side_t  fold_side;

  logic        sq_valid;
  logic [31:0] sq_root;
  sqrt_side_t  sq_side;

  logic signed [33:0] two_r;
  logic signed [34:0] l2;
  logic signed [35:0] l2p1;
  logic signed [33:0] lam1, tp1;
  logic [1:0]         st_d;
  logic [63:0]        cmag_d;
  logic [33:0]        lmag_d;
  div_side_t          lside_d;

  logic        l_valid_q;
  logic [63:0] l_num_q;
  logic [33:0] l_den_q;
  div_side_t   l_side_q;

  logic        dv_valid;
  logic [33:0] dv_quot;
  logic        dv_ovf;
  div_side_t   dv_side;

  logic [34:0]        qmag;
  logic signed [35:0] lam2, lam1x, hi, lo;
  fix_t               res_large, res_small;

  logic        out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  fix_t        out_large_q, out_large_d, out_small_q, out_small_d;
  logic [1:0]  out_status_q, out_status_d;
  fix_t        skid_large_q, skid_large_d, skid_small_q, skid_small_d;
  logic [1:0]  skid_status_q, skid_status_d;
  logic        pop;

  assign en          = !skid_valid_q;
  assign in_i.ready  = en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visc_q <= '0;
      diff_q <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_VISC) begin
        visc_q <= cfg_i.data[30:0];
      end
      if (cfg_i.index == CFG_DIFF) begin
        diff_q <= cfg_i.data[30:0];
      end
    end
  end

  dgre_mat u_mat (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.operation),
    .in_idx_i   (in_i.coef_index),
    .in_val_i   (in_i.coef_value),
    .in_x_i     (in_i.dir_x),
    .in_y_i     (in_i.dir_y),
    .visc_i     (visc_q),
    .diff_i     (diff_q),
    .valid_o    (mat_valid),
    .e_o        (mat_e),
    .w_o        (mat_w)
  );

  dgre_fold u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mat_valid),
    .e_i     (mat_e),
    .w_i     (mat_w),
    .valid_o (fold_valid),
    .rad_o   (fold_rad),
    .side_o  (fold_side)
  );

  dgre_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fold_valid),
    .rad_i   (fold_rad),
    .side_i  (fold_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // First root, taken on the side of the trace's sign.
  assign two_r = $signed({1'b0, sq_root, 1'b0});
  assign l2    = (sq_side.trace > 33'sd0) ? 35'(sq_side.trace) + 35'(two_r)
                                          : 35'(sq_side.trace) - 35'(two_r);
  assign l2p1  = 36'(l2) + 36'sd1;
  assign lam1  = l2p1[34:1];
  assign tp1   = 34'(sq_side.trace) + 34'sd1;

  always_comb begin
    if (sq_side.tz) begin
      st_d = ST_TRACE_ZERO;
    end else if (sq_side.neg) begin
      st_d = ST_COMPLEX;
    end else if (lam1 == 34'sd0) begin
      st_d = ST_ZERO_ROOT;
    end else begin
      st_d = ST_OK;
    end
  end

  assign cmag_d            = sq_side.cdet[63] ? 64'(-sq_side.cdet) : sq_side.cdet;
  assign lmag_d            = lam1[33] ? 34'(-lam1) : lam1;
  assign lside_d.lam1      = lam1;
  assign lside_d.fixed_val = (st_d == ST_COMPLEX) ? (tp1 >>> 1) : 34'sd0;
  assign lside_d.status    = st_d;
  assign lside_d.qneg      = sq_side.cdet[63] ^ lam1[33];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_valid_q <= 1'b0;
    end else if (en) begin
      l_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      l_num_q  <= cmag_d;
      l_den_q  <= lmag_d;
      l_side_q <= lside_d;
    end
  end

  dgre_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (l_valid_q),
    .num_i   (l_num_q),
    .den_i   (l_den_q),
    .side_i  (l_side_q),
    .valid_o (dv_valid),
    .quot_o  (dv_quot),
    .ovf_o   (dv_ovf),
    .side_o  (dv_side)
  );

  // An oversized quotient is clipped above any first root, which keeps the
  // ordering and the saturated value.
  assign qmag  = dv_ovf ? (35'd1 << DIV_STEPS) : {1'b0, dv_quot};
  assign lam2  = dv_side.qneg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  assign lam1x = 36'(dv_side.lam1);

  always_comb begin
    if (dv_side.status == ST_OK) begin
      hi = (lam1x > lam2) ? lam1x : lam2;
      lo = (lam1x > lam2) ? lam2 : lam1x;
    end else begin
      hi = 36'(dv_side.fixed_val);
      lo = 36'(dv_side.fixed_val);
    end
  end

  assign res_large = sat32(64'(hi));
  assign res_small = sat32(64'(lo));

  assign pop = out_valid_q && out_o.ready;

  always_comb begin
    out_valid_d   = out_valid_q;
    out_large_d   = out_large_q;
    out_small_d   = out_small_q;
    out_status_d  = out_status_q;
    skid_valid_d  = skid_valid_q;
    skid_large_d  = skid_large_q;
    skid_small_d  = skid_small_q;
    skid_status_d = skid_status_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_large_d  = skid_large_q;
        out_small_d  = skid_small_q;
        out_status_d = skid_status_q;
        skid_valid_d = 1'b0;
      end
    end else if (dv_valid) begin
      if (!out_valid_q || pop) begin
        out_valid_d  = 1'b1;
        out_large_d  = res_large;
        out_small_d  = res_small;
        out_status_d = dv_side.status;
      end else begin
        skid_valid_d  = 1'b1;
        skid_large_d  = res_large;
        skid_small_d  = res_small;
        skid_status_d = dv_side.status;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_large_q   <= out_large_d;
    out_small_q   <= out_small_d;
    out_status_q  <= out_status_d;
    skid_large_q  <= skid_large_d;
    skid_small_q  <= skid_small_d;
    skid_status_q <= skid_status_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.lambda_large = out_large_q;
  assign out_o.lambda_small = out_small_q;
  assign out_o.status       = out_status_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while the output register is empty");

  a_zero_status_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == ST_TRACE_ZERO || out_status_q == ST_ZERO_ROOT))
    |-> (out_large_q == 32'sd0 && out_small_q == 32'sd0))
    else $error("zero trace or zero root result carries nonzero eigenvalues");

  a_special_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != ST_OK) |-> (out_large_q == out_small_q))
    else $error("special-case result carries two different values");

  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == ST_OK) |-> (out_large_q >= out_small_q))
    else $error("eigenvalues leave the block out of order");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for directional_growth_rate_eigen_top
// Loads the coefficient table, sweeps directions under several viscosity and
// diffusivity settings, predicts each eigenvalue pair in the bench and checks
// every result beat in order, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import dgre_pkg::*;

  typedef struct {
    logic               op;
    logic [5:0]         idx;
    logic signed [31:0] val;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } item_t;

  typedef struct {
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    logic [1:0]         st;
  } eig_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dgre_cfg_if cfg();
  dgre_in_if  din();
  dgre_out_if dout();

  directional_growth_rate_eigen_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .in_i  (din),
    .out_o (dout)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bench copy of the block state.
  logic signed [31:0] coefs[64];
  longint visc_q;
  longint diff_q;

  item_t pending_items[$];
  eig_t  expected_eigs[$];
  int    mismatches = 0;
  bit    in_idle_on = 1'b1;
  bit    out_idle_on = 1'b1;

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint quad_sum(input longint v[4], input longint w[4]);
    longint acc;
    acc = 0;
    for (int n = 0; n < 4; n++) acc += (v[n] * w[n]) >>> 14;
    return (acc + 32768) >>> 16;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic eig_t growth_eigs(input logic signed [15:0] dx,
                                       input logic signed [15:0] dy);
    longint q[2], e[4][4], m[2][2], v[4], w[4];
    longint t, p, c, d, dlt, l2, lam1, lam2, hi, lo, s;
    longint unsigned ud, r;
    logic [1:0] st;
    eig_t res;
    q[0] = dx;
    q[1] = dy;
    for (int row = 0; row < 4; row++) begin
      for (int col = 0; col < 4; col++) begin
        for (int j = 0; j < 2; j++) begin
          for (int k = 0; k < 2; k++) begin
            v[2*j+k] = coefs[((row >> 1) << 5) | (col << 3) | (j << 2) | (k << 1) | (row & 1)];
            w[2*j+k] = q[j] * q[k];
          end
        end
        s = quad_sum(v, w);
        if (row == col) s += (row < 2) ? visc_q : diff_q;
        e[row][col] = clip32(-s);
      end
    end
    w[0] = q[1] * q[1];
    w[1] = -(q[0] * q[1]);
    w[2] = w[1];
    w[3] = q[0] * q[0];
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < 2; b++) begin
        v[0] = e[2*a][2*b];
        v[1] = e[2*a][2*b+1];
        v[2] = e[2*a+1][2*b];
        v[3] = e[2*a+1][2*b+1];
        m[a][b] = clip32(quad_sum(v, w));
      end
    end
    t = m[0][0] + m[1][1];
    p = m[0][1] * m[1][0];
    c = m[0][0] * m[1][1] - p;
    d = m[0][0] - m[1][1];
    ud = (d < 0) ? -d : d;
    dlt = longint'((ud * ud) >> 2) + p;
    hi = 0;
    lo = 0;
    st = ST_OK;
    if (t == 0) begin
      st = ST_TRACE_ZERO;
    end else if (dlt < 0) begin
      st = ST_COMPLEX;
      hi = (t + 1) >>> 1;
      lo = hi;
    end else begin
      r = int_sqrt(dlt);
      l2 = (t > 0) ? t + 2 * longint'(r) : t - 2 * longint'(r);
      lam1 = (l2 + 1) >>> 1;
      if (lam1 == 0) begin
        st = ST_ZERO_ROOT;
      end else begin
        lam2 = c / lam1;
        hi = (lam1 > lam2) ? lam1 : lam2;
        lo = (lam1 > lam2) ? lam2 : lam1;
      end
    end
    res.hi = clip32(hi);
    res.lo = clip32(lo);
    res.st = st;
    return res;
  endfunction

  // Driver: one item per beat, random gap after each accepted beat.
  item_t cur;
  int    in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      din.valid <= 1'b0;
    end else begin
      if (din.valid && din.ready) begin
        if (cur.op == OP_LOAD) coefs[cur.idx] = cur.val;
        else expected_eigs.push_back(growth_eigs(cur.dx, cur.dy));
        in_gap = in_idle_on ? $urandom_range(0, 4) : 0;
      end
      if (din.valid && !din.ready) begin
        // Hold the beat until it is taken.
      end else if (in_gap > 0) begin
        in_gap--;
        din.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur = pending_items.pop_front();
        din.valid      <= 1'b1;
        din.operation  <= cur.op;
        din.coef_index <= cur.idx;
        din.coef_value <= cur.val;
        din.dir_x      <= cur.dx;
        din.dir_y      <= cur.dy;
      end else begin
        din.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result beat and draws a stall after it.
  int out_stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    eig_t want;
    if (!rst_ni) begin
      dout.ready <= 1'b0;
    end else begin
      if (dout.valid && dout.ready) begin
        if (expected_eigs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat hi=%0d lo=%0d st=%0d",
                                         dout.lambda_large, dout.lambda_small, dout.status);
        end else begin
          want = expected_eigs.pop_front();
          if (dout.lambda_large !== want.hi || dout.lambda_small !== want.lo ||
              dout.status !== want.st) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected hi=%0d lo=%0d st=%0d, got hi=%0d lo=%0d st=%0d",
                       want.hi, want.lo, want.st,
                       dout.lambda_large, dout.lambda_small, dout.status);
          end
        end
        out_stall = out_idle_on ? $urandom_range(0, 4) : 0;
      end
      if (out_stall > 0) begin
        out_stall--;
        dout.ready <= 1'b0;
      end else begin
        dout.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic which, input logic [31:0] data);
    @(posedge clk_i);
    cfg.valid <= 1'b1;
    cfg.index <= which;
    cfg.data  <= data;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (which == CFG_VISC) visc_q = data[30:0];
    else diff_q = data[30:0];
  endtask

  task automatic push_load(input logic [5:0] idx, input logic signed [31:0] val);
    item_t it;
    it.op = OP_LOAD;
    it.idx = idx;
    it.val = val;
    it.dx = 16'($urandom);
    it.dy = 16'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic push_eval(input logic signed [15:0] dx, input logic signed [15:0] dy);
    item_t it;
    it.op = OP_EVAL;
    it.idx = 6'($urandom);
    it.val = $urandom;
    it.dx = dx;
    it.dy = dy;
    pending_items.push_back(it);
  endtask

  function automatic logic signed [31:0] rand_coef();
    if ($urandom_range(0, 1)) return $urandom;
    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  task automatic push_unit_dir();
    real ang;
    ang = $urandom_range(0, 36000) * 3.14159265358979 / 18000.0;
    push_eval(16'($rtoi($cos(ang) * 32767.0)), 16'($rtoi($sin(ang) * 32767.0)));
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || din.valid || expected_eigs.size() > 0)
      @(posedge clk_i);
    // Loads leave no result, so let the pipeline empty before the next write.
    repeat (90) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] vdat, ddat;
    cfg.valid = 1'b0;
    cfg.index = CFG_VISC;
    cfg.data = '0;
    din.valid = 1'b0;
    din.operation = OP_LOAD;
    din.coef_index = '0;
    din.coef_value = '0;
    din.dir_x = '0;
    din.dir_y = '0;
    dout.ready = 1'b0;
    visc_q = 0;
    diff_q = 0;
    foreach (coefs[n]) coefs[n] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // All-zero table with zero registers gives a zero trace.
    write_reg(CFG_VISC, 32'h0);
    write_reg(CFG_DIFF, 32'h8000_0000);
    for (int n = 0; n < 64; n++) push_load(6'(n), 32'sd0);
    push_eval(16'sd32767, 16'sd0);
    push_eval(-16'sd32768, -16'sd32768);
    drain();

    // Directed: extremes of coefficients and directions.
    for (int n = 0; n < 64; n++) push_load(6'(n), rand_coef());
    push_eval(16'sd0, 16'sd0);
    push_eval(16'sd32767, 16'sd0);
    push_eval(16'sd0, 16'sd32767);
    push_eval(-16'sd32768, 16'sd0);
    push_eval(16'sd23170, -16'sd23170);
    push_eval(16'sd32767, 16'sd32767);
    push_eval(-16'sd32768, -16'sd32768);
    push_load(6'd0, 32'sh7fff_ffff);
    push_load(6'd63, -32'sh8000_0000);
    push_load(6'd36, 32'sh7fff_ffff);
    push_eval(16'sd32767, -16'sd32768);
    push_eval(-16'sd32768, 16'sd32767);
    push_eval(16'sd1, -16'sd1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin vdat = 32'hffff_ffff; ddat = 32'h7fff_ffff; end
        1: begin vdat = 32'h0; ddat = 32'h0; end
        2: begin vdat = 32'h0001_0000; ddat = 32'h8000_8000; end
        default: begin
          vdat = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0008_0000);
          ddat = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0008_0000);
        end
      endcase
      write_reg(CFG_VISC, vdat);
      write_reg(CFG_DIFF, ddat);
      in_idle_on = (ph == 4) ? 1'b0 : 1'b1;
      out_idle_on = (ph == 3 || ph == 4) ? 1'b0 : 1'b1;
      for (int n = 0; n < 260; n++) begin
        case ($urandom_range(0, 9))
          0, 1: push_load(6'($urandom_range(0, 63)), rand_coef());
          2: push_eval(16'($urandom), 16'($urandom));
          default: push_unit_dir();
        endcase
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
